// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro takes a label, the clock, the active-low reset and a property or condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define RDDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rdds assertion failed");

// Condition never holds at a clock edge outside reset.
`define RDDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rdds forbidden condition seen");

`else

`define RDDS_ASSERT(lbl, clk, rst_n, prop)
`define RDDS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: src/rdds_pkg.sv
package rdds_pkg;

  // Field and register widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned CountW  = 4;
  localparam int unsigned PosW    = 3;
  localparam int unsigned SymW    = 7;
  localparam int unsigned CfgIdxW = 2;

  // Display store depth follows the position field width
  localparam int unsigned MaxDigits = 1 << PosW;

  // Divider steps, one quotient bit per cycle
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRadix      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDigitCount = 2'd1;

  // Reset values of the registers and the smallest radix
  localparam logic [RadixW-1:0] RadixReset = 6'd16;
  localparam logic [CountW-1:0] CountReset = 4'd4;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;

  // Request kinds
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // ASCII offsets
  localparam logic [SymW-1:0]   CodeDecimal = 7'h30;
  localparam logic [SymW-1:0]   CodeLetter  = 7'h37;
  localparam logic [RadixW-1:0] LastDecimal = 6'h09;
  localparam logic [SymW-1:0]   CodeBlank   = 7'h00;

  typedef struct packed {
    logic              req_type;
    logic [WordW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [SymW-1:0]   symbol;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [WordW-1:0]  dividend;
    logic [RadixW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WordW-1:0]  quot;
    logic [RadixW-1:0] rem;
  } div_rsp_t;

  // ASCII code of one digit
  function automatic logic [SymW-1:0] digit_code(input logic [RadixW-1:0] d);
    logic [SymW-1:0] ext;
    ext = {{(SymW-RadixW){1'b0}}, d};
    return (d > LastDecimal) ? ext + CodeLetter : ext + CodeDecimal;
  endfunction

endpackage

// File: src/rdds_div.sv
`include "assert_macros.svh"

// Restoring divider: one quotient bit per cycle.
module rdds_div import rdds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0]    quot_q, quot_d;
  logic [RadixW-1:0]   rem_q, rem_d;
  logic [RadixW-1:0]   divisor_q, divisor_d;
  logic [RadixW:0]     partial;
  logic [RadixW:0]     diff;
  logic                fits;

  // Shift in the next dividend bit and try the subtract
  assign partial = {rem_q, quot_q[WordW-1]};
  assign diff    = partial - {1'b0, divisor_q};
  assign fits    = (partial >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      quot_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? diff[RadixW-1:0] : partial[RadixW-1:0];
      quot_d = {quot_q[WordW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  `RDDS_ASSERT(a_start_busy, clk_i, rst_ni, req_i.start |=> busy_q)
  `RDDS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `RDDS_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, req_i.start && busy_q)

endmodule

// File: src/radix_digit_display_scanner_unit.sv
// Multiplexed digit display scanner with radix conversion.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes two kinds of item.
// A write item splits value into digits of the configured radix, least
// significant first, and stores ASCII codes for the positions in use;
// positions past the last nonzero digit are stored blank (0). A tick item
// advances the scan position, wrapping at the digit count, and yields one
// result item (position, symbol) on out_valid_o / out_stall_i / out_item_o.
// A write stores each position whose remaining value is zero directly and runs
// each nonzero digit through the shared bit-serial divider, with issue and store
// steps around it; the input is stalled meanwhile. A tick's result is registered
// and appears on the next cycle. While the receiver stalls a pending result,
// further items are stalled. Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i)
// is to be written by the user only while idle; the block does not enforce it.
// Reset sets radix 16, digit count 4, a blank store and scan position 0.
`include "assert_macros.svh"

module radix_digit_display_scanner_unit import rdds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RadixW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIGIT = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [RadixW-1:0] radix_q;
  logic [CountW-1:0] count_q;
  logic [RadixW-1:0] base_q, base_d;
  logic [PosW-1:0]   last_q, last_d;
  logic [PosW-1:0]   idx_q, idx_d;
  logic [WordW-1:0]  rest_q, rest_d;
  logic [PosW-1:0]   scan_q;
  logic [SymW-1:0]   store_q [MaxDigits];
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              out_busy;
  logic              in_accept;
  logic              write_acc;
  logic              tick_acc;
  logic              store_we;
  logic [SymW-1:0]   store_wdata;
  logic [RadixW-1:0] eff_radix;
  logic [CountW-1:0] eff_count;
  logic [PosW:0]     scan_inc;
  logic [PosW-1:0]   scan_next;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegRadix) begin
        radix_q <= cfg_wdata_i;
      end else if (cfg_index_i == RegDigitCount) begin
        count_q <= cfg_wdata_i[CountW-1:0];
      end
    end
  end

  // Effective radix and digit count
  assign eff_radix = (radix_q < RadixMin) ? RadixMin : radix_q;
  always_comb begin
    priority if (count_q == '0) begin
      eff_count = CountW'(1);
    end else if (count_q > CountW'(MaxDigits)) begin
      eff_count = CountW'(MaxDigits);
    end else begin
      eff_count = count_q;
    end
  end

  // Input handshake
  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || out_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign write_acc  = in_accept && (in_item_i.req_type == ReqWrite);
  assign tick_acc   = in_accept && (in_item_i.req_type == ReqTick);

  // Conversion sequencer
  always_comb begin
    state_d       = state_q;
    base_d        = base_q;
    last_d        = last_q;
    idx_d         = idx_q;
    rest_d        = rest_q;
    store_we      = 1'b0;
    store_wdata   = CodeBlank;
    div_req.start    = 1'b0;
    div_req.dividend = rest_q;
    div_req.divisor  = base_q;
    unique case (state_q)
      ST_IDLE: begin
        if (write_acc) begin
          base_d  = eff_radix;
          last_d  = PosW'(eff_count - 1'b1);
          idx_d   = '0;
          rest_d  = in_item_i.value;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (rest_q == '0) begin
          store_we = 1'b1;
          if (idx_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          store_we    = 1'b1;
          store_wdata = digit_code(div_rsp.rem);
          rest_d      = div_rsp.quot;
          if (idx_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DIGIT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    rest_q <= rest_d;
  end

  // Shared divider
  rdds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Digit store, blank after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxDigits; i++) begin
        store_q[i] <= CodeBlank;
      end
    end else if (store_we) begin
      store_q[idx_q] <= store_wdata;
    end
  end

  // Scan position advance with wrap
  assign scan_inc  = {1'b0, scan_q} + 1'b1;
  assign scan_next = (scan_inc >= eff_count) ? '0 : scan_inc[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_acc) begin
        scan_q      <= scan_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_item_q.position <= scan_next;
      out_item_q.symbol   <= store_q[scan_next];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `RDDS_ASSERT(a_write_starts, clk_i, rst_ni, write_acc |=> (state_q == ST_DIGIT))
  `RDDS_ASSERT(a_tick_result, clk_i, rst_ni, tick_acc |=> out_valid_q)
  `RDDS_ASSERT(a_done_in_wait, clk_i, rst_ni, div_rsp.done |-> (state_q == ST_WAIT))
  `RDDS_ASSERT_NEVER(a_store_idle, clk_i, rst_ni, store_we && (state_q == ST_IDLE))

endmodule
